// File: hw/rtl/sc1a_pkg.sv
// ----------------------------------------------------------------------------
// sc1a_pkg
// shared types, scancode constants and key map lookups for the decoder
// ----------------------------------------------------------------------------
package sc1a_pkg;

   localparam logic [7:0] PrefixCode  = 8'hE0;
   localparam logic [7:0] LshiftMake  = 8'h2A;
   localparam logic [7:0] RshiftMake  = 8'h36;
   localparam logic [7:0] LshiftBreak = 8'hAA;
   localparam logic [7:0] RshiftBreak = 8'hB6;
   localparam logic [7:0] CapsMake    = 8'h3A;
   localparam logic [7:0] MapLen      = 8'd58;
   localparam logic [6:0] CaseDelta   = 7'd32;
   localparam int         BreakBit    = 7;

   typedef struct packed {
      logic shift_held;
      logic caps_on;
      logic prefix_pending;
   } key_state_type;

   typedef struct packed {
      logic [6:0] char_code;
      logic       char_valid;
   } char_result_type;

   function automatic logic [6:0] plain_map(input logic [5:0] idx);
      logic [6:0] ch;
      unique case (idx)
         6'd2:  ch = 7'h31;
         6'd3:  ch = 7'h32;
         6'd4:  ch = 7'h33;
         6'd5:  ch = 7'h34;
         6'd6:  ch = 7'h35;
         6'd7:  ch = 7'h36;
         6'd8:  ch = 7'h37;
         6'd9:  ch = 7'h38;
         6'd10: ch = 7'h39;
         6'd11: ch = 7'h30;
         6'd12: ch = 7'h2d;
         6'd13: ch = 7'h3d;
         6'd14: ch = 7'h08;
         6'd16: ch = 7'h71;
         6'd17: ch = 7'h77;
         6'd18: ch = 7'h65;
         6'd19: ch = 7'h72;
         6'd20: ch = 7'h74;
         6'd21: ch = 7'h79;
         6'd22: ch = 7'h75;
         6'd23: ch = 7'h69;
         6'd24: ch = 7'h6f;
         6'd25: ch = 7'h70;
         6'd26: ch = 7'h5b;
         6'd27: ch = 7'h5d;
         6'd28: ch = 7'h0a;
         6'd30: ch = 7'h61;
         6'd31: ch = 7'h73;
         6'd32: ch = 7'h64;
         6'd33: ch = 7'h66;
         6'd34: ch = 7'h67;
         6'd35: ch = 7'h68;
         6'd36: ch = 7'h6a;
         6'd37: ch = 7'h6b;
         6'd38: ch = 7'h6c;
         6'd39: ch = 7'h3b;
         6'd40: ch = 7'h27;
         6'd41: ch = 7'h60;
         6'd43: ch = 7'h5c;
         6'd44: ch = 7'h7a;
         6'd45: ch = 7'h78;
         6'd46: ch = 7'h63;
         6'd47: ch = 7'h76;
         6'd48: ch = 7'h62;
         6'd49: ch = 7'h6e;
         6'd50: ch = 7'h6d;
         6'd51: ch = 7'h2c;
         6'd52: ch = 7'h2e;
         6'd53: ch = 7'h2f;
         6'd55: ch = 7'h2a;
         6'd57: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

   function automatic logic [6:0] upper_map(input logic [5:0] idx);
      logic [6:0] ch;
      unique case (idx)
         6'd1:  ch = 7'h01;
         6'd2:  ch = 7'h21;
         6'd3:  ch = 7'h40;
         6'd4:  ch = 7'h23;
         6'd5:  ch = 7'h24;
         6'd6:  ch = 7'h25;
         6'd7:  ch = 7'h5e;
         6'd8:  ch = 7'h26;
         6'd9:  ch = 7'h2a;
         6'd10: ch = 7'h28;
         6'd11: ch = 7'h29;
         6'd12: ch = 7'h5f;
         6'd13: ch = 7'h2b;
         6'd14: ch = 7'h08;
         6'd15: ch = 7'h09;
         6'd16: ch = 7'h51;
         6'd17: ch = 7'h57;
         6'd18: ch = 7'h45;
         6'd19: ch = 7'h52;
         6'd20: ch = 7'h54;
         6'd21: ch = 7'h59;
         6'd22: ch = 7'h55;
         6'd23: ch = 7'h49;
         6'd24: ch = 7'h4f;
         6'd25: ch = 7'h50;
         6'd26: ch = 7'h7b;
         6'd27: ch = 7'h7d;
         6'd28: ch = 7'h0a;
         6'd30: ch = 7'h41;
         6'd31: ch = 7'h53;
         6'd32: ch = 7'h44;
         6'd33: ch = 7'h46;
         6'd34: ch = 7'h47;
         6'd35: ch = 7'h48;
         6'd36: ch = 7'h4a;
         6'd37: ch = 7'h4b;
         6'd38: ch = 7'h4c;
         6'd39: ch = 7'h3a;
         6'd40: ch = 7'h22;
         6'd41: ch = 7'h7e;
         6'd43: ch = 7'h7c;
         6'd44: ch = 7'h5a;
         6'd45: ch = 7'h58;
         6'd46: ch = 7'h43;
         6'd47: ch = 7'h56;
         6'd48: ch = 7'h42;
         6'd49: ch = 7'h4e;
         6'd50: ch = 7'h4d;
         6'd51: ch = 7'h3c;
         6'd52: ch = 7'h3e;
         6'd53: ch = 7'h3f;
         6'd55: ch = 7'h2a;
         6'd57: ch = 7'h20;
         default: ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

// File: hw/rtl/scancode_set1_to_ascii.sv
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// set 1 keyboard scancode to ascii decoder with shift, caps lock and e0 prefix
// ----------------------------------------------------------------------------
// Each request carries one scancode byte and yields exactly one response with
// the ascii character (0 and tuser low when the byte makes no character). A
// request is taken every cycle while the output is not stalled; a byte passes
// an input register and then a result register before its response is driven
// on the response port. The rate is set by the combinational decode step that
// reads and updates the shift, caps lock and prefix flags for each byte.
module scancode_set1_to_ascii (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] char_code, [7] zero
   output logic       rsp_tuser    // [0] char_valid
);
   import sc1a_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   char_result_type out_result_ff;
   key_state_type   state_ff;
   key_state_type   state_in;
   key_state_type   state_dec;
   char_result_type result_dec;
   logic            advance;

   sc1a_decode u_decode (
      .scan_byte (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_dec),
      .result    (result_dec)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);
   assign state_in     = advance ? state_dec : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         out_result_ff <= result_dec;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_result_ff.char_code};
   assign rsp_tuser  = out_result_ff.char_valid;

   a_valid_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == (rsp_tdata[6:0] != 7'h00)))
      else $error("char_valid disagrees with char_code");

   a_prefix_drop : assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.prefix_pending) |=> (!rsp_tuser && rsp_tvalid))
      else $error("byte after prefix produced a character");

   a_prefix_clear : assert property (@(posedge clock) disable iff (reset)
      (advance && in_byte_ff != PrefixCode) |=> !state_ff.prefix_pending)
      else $error("prefix flag not cleared");

   a_caps_toggle : assert property (@(posedge clock) disable iff (reset)
      (state_ff.caps_on != $past(state_ff.caps_on)) |->
         ($past(advance) && $past(in_byte_ff) == CapsMake))
      else $error("caps lock changed without caps make");

endmodule

// File: hw/rtl/sc1a_decode.sv
// ----------------------------------------------------------------------------
// sc1a_decode
// one scancode byte against the key flags: character and next flags
// ----------------------------------------------------------------------------
module sc1a_decode (
   input  logic [7:0]                 scan_byte,
   input  sc1a_pkg::key_state_type    state_cur,
   output sc1a_pkg::key_state_type    state_nxt,
   output sc1a_pkg::char_result_type  result
);
   import sc1a_pkg::*;

   logic       shift_eff;
   logic       caps_eff;
   logic [6:0] map_ch;
   logic [6:0] ch;

   always_comb begin
      state_nxt = state_cur;
      shift_eff = state_cur.shift_held;
      caps_eff  = state_cur.caps_on;
      map_ch    = 7'h00;
      ch        = 7'h00;
      priority if (scan_byte == PrefixCode) begin
         state_nxt.prefix_pending = 1'b1;
      end else if (state_cur.prefix_pending) begin
         state_nxt.prefix_pending = 1'b0;
      end else if (scan_byte[BreakBit]) begin
         if (scan_byte == LshiftBreak || scan_byte == RshiftBreak) begin
            state_nxt.shift_held = 1'b0;
         end
      end else begin
         if (scan_byte == LshiftMake || scan_byte == RshiftMake) begin
            shift_eff = 1'b1;
         end
         if (scan_byte == CapsMake) begin
            caps_eff = ~state_cur.caps_on;
         end
         state_nxt.shift_held = shift_eff;
         state_nxt.caps_on    = caps_eff;
         if (scan_byte < MapLen) begin
            map_ch = shift_eff ? upper_map(scan_byte[5:0]) : plain_map(scan_byte[5:0]);
         end
         ch = map_ch;
         // caps lock swaps letter case
         if (caps_eff) begin
            if (map_ch >= 7'h61 && map_ch <= 7'h7a) begin
               ch = map_ch - CaseDelta;
            end else if (map_ch >= 7'h41 && map_ch <= 7'h5a) begin
               ch = map_ch + CaseDelta;
            end
         end
      end
      result.char_code  = ch;
      result.char_valid = (ch != 7'h00);
   end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// testbench for the set 1 scancode to ascii decoder
// ----------------------------------------------------------------------------
// Scancode bytes are sent over the request stream. A short directed list runs
// first, then random typing (key presses and releases with shift, caps lock
// and e0 prefixes) mixed with random byte noise. Each accepted request is run
// through a local decoder that keeps its own shift, caps lock and prefix
// flags; the character it predicts is queued and compared with each response
// as it arrives. Sender and receiver pause at random in the first two phases.
// ----------------------------------------------------------------------------
module tb_top;
   import sc1a_pkg::*;

   localparam int WatchdogLimit = 1000;
   localparam int DrainCycles   = 8;

   localparam logic [0:57][7:0] PlainKeys = {
      8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
      8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
      8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00,
      8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
      8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e,
      8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a, 8'h00, 8'h20
   };

   localparam logic [0:57][7:0] ShiftKeys = {
      8'h00, 8'h01, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e, 8'h26, 8'h2a,
      8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
      8'h54, 8'h59, 8'h55, 8'h49, 8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00,
      8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
      8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4e,
      8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a, 8'h00, 8'h20
   };

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] scan_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [6:0] char_code, [7] zero
   logic       rsp_tuser;            // [0] char_valid

   key_state_type   keyboard = '0;
   char_result_type expected_chars [$];
   int              failures        = 0;
   int              quiet_cycles    = 0;
   int              sender_idle_pct = 0;
   int              sink_stall_pct  = 0;

   scancode_set1_to_ascii i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic char_result_type decode_scan(input logic [7:0] scan);
      char_result_type res;
      logic [6:0]      ch;
      ch = '0;
      if (scan == PrefixCode) begin
         keyboard.prefix_pending = 1'b1;
      end else if (keyboard.prefix_pending) begin
         keyboard.prefix_pending = 1'b0;
      end else if (scan[BreakBit]) begin
         if (scan == LshiftBreak || scan == RshiftBreak) begin
            keyboard.shift_held = 1'b0;
         end
      end else begin
         if (scan == LshiftMake || scan == RshiftMake) begin
            keyboard.shift_held = 1'b1;
         end
         if (scan == CapsMake) begin
            keyboard.caps_on = !keyboard.caps_on;
         end
         if (scan < MapLen) begin
            ch = keyboard.shift_held ? ShiftKeys[scan[5:0]][6:0]
                                     : PlainKeys[scan[5:0]][6:0];
            if (keyboard.caps_on) begin
               if (ch >= 7'h61 && ch <= 7'h7a) begin
                  ch = ch - CaseDelta;
               end else if (ch >= 7'h41 && ch <= 7'h5a) begin
                  ch = ch + CaseDelta;
               end
            end
         end
      end
      res.char_code  = ch;
      res.char_valid = (ch != 7'h00);
      return res;
   endfunction

   // request tracking, response check, receiver stalls and watchdog
   always @(posedge clock) begin : char_check
      char_result_type got;
      char_result_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_chars.push_back(decode_scan(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.char_code  = rsp_tdata[6:0];
            got.char_valid = rsp_tuser;
            if (expected_chars.size() == 0) begin
               $error("unexpected response char_code %h char_valid %b",
                      got.char_code, got.char_valid);
               failures++;
            end else begin
               want = expected_chars.pop_front();
               if (got.char_code !== want.char_code) begin
                  $error("char_code expected %h actual %h", want.char_code, got.char_code);
                  failures++;
               end
               if (got.char_valid !== want.char_valid) begin
                  $error("char_valid expected %b actual %b",
                         want.char_valid, got.char_valid);
                  failures++;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WatchdogLimit) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   task automatic send_scan(input logic [7:0] scan);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= scan;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic test_special_codes;
      logic [7:0] codes [$];
      codes = '{8'h00, 8'hFF, 8'h7F, LshiftMake, 8'h01, 8'h0F, 8'h10, PrefixCode,
                LshiftBreak, 8'h10, LshiftBreak, 8'h0F, CapsMake, 8'h1E, RshiftMake,
                8'h27, RshiftBreak, 8'h9E, 8'h1E, CapsMake, PrefixCode, PrefixCode,
                8'h1E, PrefixCode, 8'h3B};
      foreach (codes[i]) send_scan(codes[i]);
   endtask

   task automatic test_typing(input int key_count);
      logic [7:0] key;
      logic [7:0] shift_key;
      int         pick;
      repeat (key_count) begin
         pick = $urandom_range(99);
         key  = 8'($urandom_range(57, 1));
         if (pick < 15) begin
            shift_key = $urandom_range(1) ? LshiftMake : RshiftMake;
            send_scan(shift_key);
            repeat ($urandom_range(3, 1)) begin
               key = 8'($urandom_range(57, 1));
               send_scan(key);
               send_scan(key | 8'h80);
            end
            send_scan(shift_key | 8'h80);
         end else if (pick < 22) begin
            send_scan(CapsMake);
            send_scan(CapsMake | 8'h80);
         end else if (pick < 32) begin
            send_scan(PrefixCode);
            send_scan(8'($urandom_range(255)));
         end else begin
            send_scan(key);
            if ($urandom_range(3) != 0) send_scan(key | 8'h80);
         end
      end
   endtask

   task automatic test_byte_noise(input int byte_count);
      repeat (byte_count) send_scan(8'($urandom_range(255)));
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 16;
      sink_stall_pct  = 63;
      test_special_codes();
      test_typing(50);
      test_byte_noise(25);

      sender_idle_pct = 63;
      sink_stall_pct  = 16;
      test_typing(50);
      test_byte_noise(25);

      sender_idle_pct = 0;
      sink_stall_pct  = 0;
      test_typing(50);
      test_byte_noise(25);

      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
